// File: rtl/core/kpd_pkg.sv
// ============================================================================
// kpd_pkg - shared types and constants for the keypad debouncer
// Widths, register indexes, reset values and the structs passed between the
// key lanes, the result merge stage and the top level.
// ============================================================================
package kpd_pkg;

    // Key and time configuration
    localparam int NUM_KEYS    = 6;
    localparam int TIME_BITS   = 32;
    localparam int REPEAT_KEYS = 4;
    localparam int OUT_KEYS    = 6;

    // Payload widths
    localparam int PORT_W     = 8;
    localparam int PIN_W      = 3;
    localparam int NOW_W      = 32;
    localparam int MS_W       = 16;
    localparam int MAP_W      = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PIN_MAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RATE  = 3'd5;

    // Reset values of the timing registers
    localparam logic [MS_W-1:0] DEBOUNCE_RST     = 16'd30;
    localparam logic [MS_W-1:0] REPEAT_DELAY_RST = 16'd350;
    localparam logic [MS_W-1:0] REPEAT_RATE_RST  = 16'd120;

    // Settings seen by every key lane
    typedef struct packed {
        logic            active_low;
        logic [MS_W-1:0] debounce_time;
        logic [MS_W-1:0] repeat_delay;
        logic [MS_W-1:0] repeat_interval;
    } lane_cfg_t;

    // What one lane reports for the current word
    typedef struct packed {
        logic ev;
        logic level;
    } lane_out_t;

    // One result word
    typedef struct packed {
        logic [OUT_KEYS-1:0] ev;
        logic [OUT_KEYS-1:0] held_mask;
    } result_t;

endpackage

// File: rtl/core/kpd_ifs.sv
// ============================================================================
// kpd_ifs - handshake channels of the keypad debouncer
// Sample input channel, result output channel and configuration write channel.
// ============================================================================
interface kpd_sample_if;
    import kpd_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [PORT_W-1:0] raw_port;
    logic [NOW_W-1:0]  now_ms;

    modport source (output valid, output cmd, output raw_port, output now_ms, input ready);
    modport sink   (input valid, input cmd, input raw_port, input now_ms, output ready);
endinterface

interface kpd_result_if;
    import kpd_pkg::*;

    logic                valid;
    logic                ready;
    logic                ev_up;
    logic                ev_down;
    logic                ev_left;
    logic                ev_right;
    logic                ev_ok;
    logic                ev_back;
    logic [OUT_KEYS-1:0] held_mask;

    modport source (output valid, output ev_up, output ev_down, output ev_left,
                    output ev_right, output ev_ok, output ev_back, output held_mask,
                    input ready);
    modport sink   (input valid, input ev_up, input ev_down, input ev_left,
                    input ev_right, input ev_ok, input ev_back, input held_mask,
                    output ready);
endinterface

interface kpd_cfg_if;
    import kpd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/kpd_lane.sv
// ============================================================================
// kpd_lane - debounce and auto-repeat core for one key
// Holds the key's stable level and its three timestamps and updates them
// for every sample word accepted while enabled.
// ============================================================================
module kpd_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             cmd,
    input  logic [kpd_pkg::PORT_W-1:0]       raw_port,
    input  logic [kpd_pkg::NOW_W-1:0]        now_ms,
    input  logic [kpd_pkg::PIN_W-1:0]        pin,
    input  logic                             repeat_en,
    input  kpd_pkg::lane_cfg_t               cfg,
    output kpd_pkg::lane_out_t               result
);
    import kpd_pkg::*;

    logic                 stable_reg, stable_next;
    logic [TIME_BITS-1:0] change_reg, change_next;
    logic [TIME_BITS-1:0] press_reg, press_next;
    logic [TIME_BITS-1:0] rep_reg, rep_next;

    logic                 lvl;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_change;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] since_rep;
    logic                 differ;
    logic                 accept_chg;
    logic                 press;
    logic                 do_repeat;

    assign now = now_ms[TIME_BITS-1:0];
    assign lvl = raw_port[pin] ^ cfg.active_low;

    // Wrapping elapsed times
    assign since_change = now - change_reg;
    assign since_press  = now - press_reg;
    assign since_rep    = now - rep_reg;

    always_comb
    begin
        differ     = (lvl != stable_reg);
        accept_chg = differ && (since_change >= TIME_BITS'(cfg.debounce_time));
        press      = accept_chg && lvl;

        stable_next = accept_chg ? lvl : stable_reg;
        change_next = (!differ || accept_chg) ? now : change_reg;
        press_next  = press ? now : press_reg;

        // A press just restarted both timers, so elapsed is zero for this word
        do_repeat = repeat_en && stable_next
                    && ((press ? '0 : since_press) >= TIME_BITS'(cfg.repeat_delay))
                    && ((press ? '0 : since_rep) >= TIME_BITS'(cfg.repeat_interval));
        rep_next  = (press || do_repeat) ? now : rep_reg;

        if (cmd)
        begin
            stable_next = lvl;
            change_next = now;
            press_next  = now;
            rep_next    = now;
            do_repeat   = 1'b0;
            press       = 1'b0;
        end

        result.ev    = step && (press || do_repeat);
        result.level = step ? stable_next : stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            change_reg <= '0;
            press_reg  <= '0;
            rep_reg    <= '0;
        end
        else if (step)
        begin
            stable_reg <= stable_next;
            change_reg <= change_next;
            press_reg  <= press_next;
            rep_reg    <= rep_next;
        end
    end

endmodule

// File: rtl/core/kpd_merge.sv
// ============================================================================
// kpd_merge - result merge and output buffer
// Packs the lane results into one result word and holds it in an output
// register backed by a skid register.
// ============================================================================
module kpd_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kpd_pkg::lane_out_t lanes [kpd_pkg::NUM_KEYS],
    output logic               room,
    kpd_result_if.source       report
);
    import kpd_pkg::*;

    result_t word;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    pop;

    // Combine lane findings; keys past the lane count read as zero
    always_comb
    begin
        word = '0;
        for (int k = 0; k < OUT_KEYS; k++)
        begin
            if (k < NUM_KEYS)
            begin
                word.ev[k]        = lanes[k].ev;
                word.held_mask[k] = lanes[k].level;
            end
        end
    end

    assign room = !skid_valid_reg;
    assign pop  = main_valid_reg && report.ready;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = word;
                skid_valid_next = push;
            end
            else
            begin
                main_next       = word;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign report.valid     = main_valid_reg;
    assign report.ev_up     = main_reg.ev[0];
    assign report.ev_down   = main_reg.ev[1];
    assign report.ev_left   = main_reg.ev[2];
    assign report.ev_right  = main_reg.ev[3];
    assign report.ev_ok     = main_reg.ev[4];
    assign report.ev_back   = main_reg.ev[5];
    assign report.held_mask = main_reg.held_mask;

endmodule

// File: rtl/core/keypad_debounce_autorepeat.sv
// ============================================================================
// keypad_debounce_autorepeat - six-key debouncer with arrow auto-repeat
// Maps raw port bits to key levels, debounces each key in its own lane and
// merges press and repeat events with the held mask into one result word.
// ============================================================================
//
//   channel  | dir | handshake     | word contents
//   ---------+-----+---------------+-----------------------------------------
//   sample   | in  | valid/ready   | cmd, raw_port, now_ms
//   report   | out | valid/ready   | ev_up..ev_back, held_mask
//   cfg      | in  | valid/ready   | index, data (register write)
//
// One sample word is taken per cycle while the skid register is empty; its result
// word is registered in the merge output register, or in the skid register when
// report is stalled. Each key does its three wrapping subtract-compares in its lane.
// Reset clears all key state and loads the register defaults.
// A stalled report holds its word; a skid register takes one more word, so
// sample stays ready until two results are waiting. cfg is always ready.
//
module keypad_debounce_autorepeat (
    input  logic        clk,
    input  logic        rst_n,
    kpd_sample_if.sink  sample,
    kpd_result_if.source report,
    kpd_cfg_if.sink     cfg
);
    import kpd_pkg::*;

    localparam int MAP_EXT_W = MAP_W + PIN_W * NUM_KEYS;

    // Configuration registers
    logic            enable_reg;
    logic [MAP_W-1:0] key_pin_map_reg;
    logic            active_low_reg;
    logic [MS_W-1:0] debounce_reg;
    logic [MS_W-1:0] repeat_delay_reg;
    logic [MS_W-1:0] repeat_rate_reg;

    logic                 cfg_write;
    logic                 accept;
    logic                 step;
    logic                 room;
    logic [MAP_EXT_W-1:0] map_ext;
    lane_cfg_t            lane_cfg;
    lane_out_t            lanes [NUM_KEYS];

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Write the addressed register; drop writes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            key_pin_map_reg  <= '0;
            active_low_reg   <= 1'b1;
            debounce_reg     <= DEBOUNCE_RST;
            repeat_delay_reg <= REPEAT_DELAY_RST;
            repeat_rate_reg  <= REPEAT_RATE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_ENABLE:       enable_reg       <= cfg.data[0];
                REG_KEY_PIN_MAP:  key_pin_map_reg  <= cfg.data[MAP_W-1:0];
                REG_ACTIVE_LOW:   active_low_reg   <= cfg.data[0];
                REG_DEBOUNCE:     debounce_reg     <= cfg.data[MS_W-1:0];
                REG_REPEAT_DELAY: repeat_delay_reg <= cfg.data[MS_W-1:0];
                REG_REPEAT_RATE:  repeat_rate_reg  <= cfg.data[MS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign lane_cfg.active_low      = active_low_reg;
    assign lane_cfg.debounce_time   = debounce_reg;
    assign lane_cfg.repeat_delay    = repeat_delay_reg;
    assign lane_cfg.repeat_interval = repeat_rate_reg;

    // Keys whose map field lies past the register read port bit 0
    assign map_ext = {{(PIN_W * NUM_KEYS){1'b0}}, key_pin_map_reg};

    // Advance lanes only on an accepted word while enabled
    assign sample.ready = room;
    assign accept       = sample.valid && sample.ready;
    assign step         = accept && enable_reg;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kpd_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .cmd       (sample.cmd),
            .raw_port  (sample.raw_port),
            .now_ms    (sample.now_ms),
            .pin       (map_ext[PIN_W*k +: PIN_W]),
            .repeat_en ((k < REPEAT_KEYS) ? 1'b1 : 1'b0),
            .cfg       (lane_cfg),
            .result    (lanes[k])
        );
    end

    // Merge lane results and buffer the result word
    kpd_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .lanes  (lanes),
        .room   (room),
        .report (report)
    );

endmodule
